// ----- rtl/assert_macros.svh -----
// Assertion macros included by the hasher core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions of the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam logic [1:0] OP_ABSORB  = 2'd0;
    localparam logic [1:0] OP_DIGEST  = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        last_word;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    // Control from the sequencer to the compression unit.
    typedef struct packed {
        logic       load;
        logic       step;
        logic [5:0] round;
    } cmp_ctrl_t;

    typedef logic [7:0][31:0]  hash_t;
    typedef logic [15:0][31:0] block_t;

    localparam hash_t INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

// ----- rtl/sha_round_unit.sv -----
// ----------------------------------------------------------------------------
// sha_round_unit
// Shared SHA-256 round datapath: one round and one schedule word per cycle while step is set.
// ----------------------------------------------------------------------------
module sha_round_unit (
    input  logic               clk,
    input  sha_pkg::cmp_ctrl_t ctrl,
    input  sha_pkg::hash_t     hash_in,
    input  sha_pkg::block_t    block_in,
    output sha_pkg::hash_t     work
);

    sha_pkg::hash_t  work_reg;
    sha_pkg::hash_t  work_next;
    sha_pkg::block_t sched_reg;
    sha_pkg::block_t sched_next;

    logic [31:0] a, e, s0, s1, ch, mj, t1, t2, w, x, y, wn;

    always_comb
    begin
        a  = work_reg[0];
        e  = work_reg[4];
        w  = sched_reg[0];
        s1 = sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25);
        ch = work_reg[6] ^ (e & (work_reg[5] ^ work_reg[6]));
        t1 = work_reg[7] + s1 + ch + sha_pkg::round_k(ctrl.round) + w;
        s0 = sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22);
        mj = (a & work_reg[1]) | (work_reg[2] & (a | work_reg[1]));
        t2 = s0 + mj;
        // Sliding 16-word schedule window: w[t+16] from w[t+1], w[t+14], w[t+9], w[t].
        x  = sched_reg[1];
        y  = sched_reg[14];
        wn = (sha_pkg::rotr(y, 17) ^ sha_pkg::rotr(y, 19) ^ (y >> 10)) + sched_reg[9]
           + (sha_pkg::rotr(x, 7) ^ sha_pkg::rotr(x, 18) ^ (x >> 3)) + w;
        work_next  = work_reg;
        sched_next = sched_reg;
        if (ctrl.load)
        begin
            work_next  = hash_in;
            sched_next = block_in;
        end
        else if (ctrl.step)
        begin
            work_next[7] = work_reg[6];
            work_next[6] = work_reg[5];
            work_next[5] = work_reg[4];
            work_next[4] = work_reg[3] + t1;
            work_next[3] = work_reg[2];
            work_next[2] = work_reg[1];
            work_next[1] = work_reg[0];
            work_next[0] = t1 + t2;
            sched_next   = {wn, sched_reg[15:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg  <= work_next;
        sched_reg <= sched_next;
    end

    assign work = work_reg;

endmodule

// ----- rtl/sha256_byte_stream_hasher_core.sv -----
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_core
// Byte-serial SHA-256 with a non-destructive digest readout.
// ----------------------------------------------------------------------------
// Absorb: a byte is taken in idle; a byte that completes a block also loads
// the shared round unit, which then runs 64 rounds, followed by one fold.
// Digest: a pad load, 64 rounds and a fold for each of one or two padded
// blocks, then eight output transactions at one per cycle when not stalled.
// Restart: taken in idle. Reset (asynchronous, rst_n low) loads the initial
// hash, clears the block and the byte count; no clearing pass is needed.
module sha256_byte_stream_hasher_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  sha_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output sha_pkg::out_item_t out_data
);
`include "assert_macros.svh"

    sha_pkg::state_t state_reg, state_next;
    sha_pkg::hash_t  chain_reg, chain_next;      // running chaining value
    sha_pkg::block_t block_reg, block_next;      // running block buffer
    logic [60:0]     total_reg, total_next;      // byte count mod 2^61
    sha_pkg::hash_t  pchain_reg, pchain_next;    // digest working copy
    sha_pkg::block_t pblock_reg, pblock_next;
    logic            pad_mode_reg, pad_mode_next;  // compressing the padded copy
    logic            second_reg, second_next;      // a second padded block follows
    logic [5:0]      round_reg, round_next;
    logic [2:0]      word_reg, word_next;

    sha_pkg::cmp_ctrl_t ctrl;
    sha_pkg::hash_t     work;
    sha_pkg::hash_t     fold;
    sha_pkg::block_t    put_block;
    sha_pkg::block_t    pad1, pad2;
    logic [63:0]        bits;
    logic [5:0]         pos;
    logic               in_take;

    assign in_take = in_valid && !in_stall;
    assign pos     = total_reg[5:0];
    assign bits    = {total_reg, 3'b000};

    sha_round_unit u_round (
        .clk      (clk),
        .ctrl     (ctrl),
        .hash_in  (pad_mode_reg ? pchain_reg : chain_reg),
        .block_in (pad_mode_reg ? pblock_reg : put_block),
        .work     (work)
    );

    // The byte being absorbed is merged so a full block reaches the unit directly.
    always_comb
    begin
        put_block = block_reg;
        put_block[pos[5:2]][8 * (3 - pos[1:0]) +: 8] = in_data.byte_value;
    end

    // Padded blocks: 0x80 at pos, then length in the last two words; when pos
    // is 56 or more the length goes into a second, otherwise empty, block.
    always_comb
    begin
        pad1 = block_reg;
        pad1[pos[5:2]][8 * (3 - pos[1:0]) +: 8] = 8'h80;
        pad2 = '0;
        pad2[14] = bits[63:32];
        pad2[15] = bits[31:0];
        if (pos < 6'd56)
        begin
            pad1[14] = bits[63:32];
            pad1[15] = bits[31:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            fold[i] = (pad_mode_reg ? pchain_reg[i] : chain_reg[i]) + work[i];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    if (in_data.op == sha_pkg::OP_DIGEST)
                    begin
                        state_next = sha_pkg::ST_PAD;
                    end
                    else if (in_data.op == sha_pkg::OP_ABSORB && pos == 6'd63)
                    begin
                        state_next = sha_pkg::ST_ROUND;
                    end
                end
            end
            sha_pkg::ST_PAD:   state_next = sha_pkg::ST_ROUND;
            sha_pkg::ST_ROUND:
            begin
                if (round_reg == 6'd63)
                begin
                    state_next = sha_pkg::ST_FOLD;
                end
            end
            sha_pkg::ST_FOLD:
            begin
                if (!pad_mode_reg)
                begin
                    state_next = sha_pkg::ST_IDLE;
                end
                else if (second_reg)
                begin
                    state_next = sha_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha_pkg::ST_EMIT;
                end
            end
            sha_pkg::ST_EMIT:
            begin
                if (!out_stall && word_reg == 3'd7)
                begin
                    state_next = sha_pkg::ST_IDLE;
                end
            end
            default: state_next = sha_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath control.
    always_comb
    begin
        in_stall      = (state_reg != sha_pkg::ST_IDLE);
        out_valid     = (state_reg == sha_pkg::ST_EMIT);
        out_data.digest_word = pchain_reg[word_reg];
        out_data.last_word   = (word_reg == 3'd7);
        ctrl.load  = 1'b0;
        ctrl.step  = (state_reg == sha_pkg::ST_ROUND);
        ctrl.round = round_reg;
        chain_next    = chain_reg;
        block_next    = block_reg;
        total_next    = total_reg;
        pchain_next   = pchain_reg;
        pblock_next   = pblock_reg;
        pad_mode_next = pad_mode_reg;
        second_next   = second_reg;
        round_next    = (state_reg == sha_pkg::ST_ROUND) ? round_reg + 6'd1 : 6'd0;
        word_next     = word_reg;
        case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                word_next = 3'd0;
                if (in_take)
                begin
                    case (in_data.op)
                        sha_pkg::OP_ABSORB:
                        begin
                            total_next = total_reg + 61'd1;
                            block_next = put_block;
                            pad_mode_next = 1'b0;
                            if (pos == 6'd63)
                            begin
                                ctrl.load = 1'b1;
                            end
                        end
                        sha_pkg::OP_RESTART:
                        begin
                            chain_next = sha_pkg::INIT_HASH;
                            block_next = '0;
                            total_next = '0;
                        end
                        sha_pkg::OP_DIGEST:
                        begin
                            pad_mode_next = 1'b1;
                            pchain_next   = chain_reg;
                            pblock_next   = pad1;
                            second_next   = (pos >= 6'd56);
                        end
                        default: ;
                    endcase
                end
            end
            sha_pkg::ST_PAD:
            begin
                ctrl.load = 1'b1;
            end
            sha_pkg::ST_FOLD:
            begin
                if (pad_mode_reg)
                begin
                    pchain_next = fold;
                    pblock_next = pad2;
                    second_next = 1'b0;
                    // Pad mode ends with the last padded block, so the unit
                    // sees the running hash again on the next full block.
                    pad_mode_next = second_reg;
                end
                else
                begin
                    chain_next = fold;
                    block_next = '0;
                end
            end
            sha_pkg::ST_EMIT:
            begin
                if (!out_stall)
                begin
                    word_next = word_reg + 3'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sha_pkg::ST_IDLE;
            chain_reg    <= sha_pkg::INIT_HASH;
            block_reg    <= '0;
            total_reg    <= '0;
            pad_mode_reg <= 1'b0;
            second_reg   <= 1'b0;
            round_reg    <= '0;
            word_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            chain_reg    <= chain_next;
            block_reg    <= block_next;
            total_reg    <= total_next;
            pad_mode_reg <= pad_mode_next;
            second_reg   <= second_next;
            round_reg    <= round_next;
            word_reg     <= word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pchain_reg <= pchain_next;
        pblock_reg <= pblock_next;
    end

    // The last digest word always closes the run and returns to idle.
    `ASSERT_NEXT(a_last_idle, out_valid && !out_stall && out_data.last_word,
                 state_reg == sha_pkg::ST_IDLE)
    // A full block always starts a compression.
    `ASSERT_NEXT(a_full_block, in_take && in_data.op == sha_pkg::OP_ABSORB && pos == 6'd63,
                 state_reg == sha_pkg::ST_ROUND && round_reg == 6'd0)
    // Output is never shown while an input may be taken.
    `ASSERT_IMPL(a_excl, out_valid, in_stall)

endmodule

// ----- test/sha256_byte_stream_hasher_core_test.sv -----
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_core_test
// Self-checking bench for the byte-serial SHA-256 core. Absorb, digest and
// restart transactions are queued by an initial block, driven with random
// gaps, and every digest word is checked against an in-bench SHA-256 model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_core_test;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 160;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    sha_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_stall;
    sha_pkg::out_item_t out_data;

    sha256_byte_stream_hasher_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Model state: running hash, partial block and message length in bytes.
    sha_pkg::hash_t  model_hash;
    sha_pkg::block_t model_block;
    logic [60:0]     model_len;

    // Transactions waiting to be driven, and digest words still due.
    sha_pkg::in_item_t  pending_items[$];
    sha_pkg::out_item_t due_words[$];

    int  error_count;
    int  digest_count;
    int  word_count;
    bit  hold_sender;

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic logic [31:0] ror(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // One 64-round compression of blk into hv. The block itself is cleared by
    // the caller.
    function automatic sha_pkg::hash_t sha_compress(input sha_pkg::hash_t hv,
                                                    input sha_pkg::block_t blk);
        logic [31:0] sched[64];
        logic [31:0] k_tab[64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        sha_pkg::hash_t res;
        k_tab = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        for (int t = 0; t < 16; t++)
            sched[t] = blk[t];
        for (int t = 16; t < 64; t++)
            sched[t] = (ror(sched[t-2], 17) ^ ror(sched[t-2], 19) ^ (sched[t-2] >> 10))
                     + sched[t-7]
                     + (ror(sched[t-15], 7) ^ ror(sched[t-15], 18) ^ (sched[t-15] >> 3))
                     + sched[t-16];
        a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
        e = hv[4]; f = hv[5]; g = hv[6]; h = hv[7];
        for (int t = 0; t < 64; t++)
        begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + (g ^ (e & (f ^ g)))
               + k_tab[t] + sched[t];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) | (c & (a | b)));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        res[0] = hv[0] + a; res[1] = hv[1] + b; res[2] = hv[2] + c; res[3] = hv[3] + d;
        res[4] = hv[4] + e; res[5] = hv[5] + f; res[6] = hv[6] + g; res[7] = hv[7] + h;
        return res;
    endfunction

    // Places a byte at position pos of the block, big-endian within each word,
    // and compresses when the block fills.
    task automatic place_byte(inout sha_pkg::hash_t hv, inout sha_pkg::block_t blk,
                              inout logic [5:0] pos, input logic [7:0] val);
        blk[pos[5:2]] |= 32'(val) << (8 * (3 - pos[1:0]));
        pos = pos + 6'd1;
        if (pos == 6'd0)
        begin
            hv  = sha_compress(hv, blk);
            blk = '0;
        end
    endtask

    // Applies one accepted transaction to the model and queues any digest words.
    task automatic predict_hash(input sha_pkg::in_item_t item);
        sha_pkg::hash_t     ph;
        sha_pkg::block_t    pb;
        logic [5:0]         pos;
        logic [63:0]        bits;
        sha_pkg::out_item_t w;
        pos = model_len[5:0];
        case (item.op)
            sha_pkg::OP_ABSORB:
            begin
                place_byte(model_hash, model_block, pos, item.byte_value);
                model_len = model_len + 61'd1;
            end
            sha_pkg::OP_RESTART:
            begin
                model_hash  = sha_pkg::INIT_HASH;
                model_block = '0;
                model_len   = '0;
            end
            sha_pkg::OP_DIGEST:
            begin
                // Padding works on copies; the running hash stays as it is.
                ph   = model_hash;
                pb   = model_block;
                bits = {model_len, 3'b000};
                place_byte(ph, pb, pos, 8'h80);
                while (pos != 6'd56)
                    place_byte(ph, pb, pos, 8'h00);
                for (int k = 7; k >= 0; k--)
                    place_byte(ph, pb, pos, bits[8*k +: 8]);
                for (int k = 0; k < 8; k++)
                begin
                    w.digest_word = ph[k];
                    w.last_word   = (k == 7);
                    due_words = {due_words, w};
                end
                digest_count++;
            end
            default:
            begin
                // The unused op code leaves the state alone.
            end
        endcase
    endtask

    // Driver: presents each pending transaction after a random gap and holds it
    // until accepted. A hold request stalls the sender until all words are in.
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap <= 0;
        end
        else if (in_valid && !in_stall)
        begin
            predict_hash(in_data);
            if (send_gap == 0 && pending_items.size() > 0 && !hold_sender)
            begin
                in_data  <= pending_items.pop_front();
                send_gap <= $urandom_range(0, 4);
            end
            else
            begin
                in_valid <= 1'b0;
                send_gap <= (send_gap == 0) ? 0 : send_gap - 1;
            end
        end
        else if (!in_valid)
        begin
            if (send_gap > 0)
                send_gap <= send_gap - 1;
            else if (pending_items.size() > 0
                     && !(hold_sender && due_words.size() > 0))
            begin
                in_valid <= 1'b1;
                in_data  <= pending_items.pop_front();
                send_gap <= $urandom_range(0, 4);
            end
        end
    end

    // Monitor: draws a random stall length per digest word and checks each
    // accepted word against the oldest expected one.
    int stall_left;
    int stall_draw;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                word_count++;
                if (due_words.size() == 0)
                begin
                    $display("%0t: unexpected digest word, expected none, actual %h last %b",
                             $time, out_data.digest_word, out_data.last_word);
                    error_count++;
                end
                else
                begin
                    if (out_data.digest_word !== due_words[0].digest_word)
                    begin
                        $display("%0t: digest_word mismatch, expected %h actual %h",
                                 $time, due_words[0].digest_word, out_data.digest_word);
                        error_count++;
                    end
                    if (out_data.last_word !== due_words[0].last_word)
                    begin
                        $display("%0t: last_word mismatch, expected %b actual %b",
                                 $time, due_words[0].last_word, out_data.last_word);
                        error_count++;
                    end
                    void'(due_words.pop_front());
                end
                stall_draw = $urandom_range(0, 4);
                stall_left <= stall_draw;
                out_stall  <= (stall_draw > 0);
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall  <= (stall_left > 1);
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic queue_item(input logic [1:0] op, input logic [7:0] val);
        sha_pkg::in_item_t it;
        it.op         = op;
        it.byte_value = val;
        pending_items = {pending_items, it};
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || in_valid || due_words.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int n;
        int r;
        error_count   = 0;
        digest_count  = 0;
        word_count    = 0;
        hold_sender   = 0;
        model_hash    = sha_pkg::INIT_HASH;
        model_block   = '0;
        model_len     = '0;
        rst_n         = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: digest of the empty message, "abc", an ignored op code with
        // all byte bits set, a repeated digest, restart, and extreme bytes.
        queue_item(sha_pkg::OP_DIGEST, 8'hff);
        queue_item(sha_pkg::OP_ABSORB, 8'h61);
        queue_item(sha_pkg::OP_ABSORB, 8'h62);
        queue_item(sha_pkg::OP_ABSORB, 8'h63);
        queue_item(OP_UNUSED, 8'hff);
        queue_item(sha_pkg::OP_DIGEST, 8'h00);
        queue_item(sha_pkg::OP_DIGEST, 8'h55);
        queue_item(sha_pkg::OP_RESTART, 8'haa);
        queue_item(sha_pkg::OP_ABSORB, 8'h00);
        queue_item(sha_pkg::OP_ABSORB, 8'hff);
        queue_item(sha_pkg::OP_DIGEST, 8'h00);

        // The sender waits for every digest word before going on.
        wait_drained();
        hold_sender = 1;
        queue_item(sha_pkg::OP_DIGEST, 8'h00);
        wait_drained();
        hold_sender = 0;

        // One message grown byte by byte and digested at lengths that put the
        // pad byte just before byte 56, on it, at the end of a block, and on
        // either side of a full block. The digest at 63 bytes is followed by
        // the byte that completes the block.
        queue_item(sha_pkg::OP_RESTART, 8'h00);
        for (int j = 0; j < 65; j++)
        begin
            queue_item(sha_pkg::OP_ABSORB, 8'($urandom_range(0, 255)));
            if (j == 54 || j == 55 || j == 62 || j == 63 || j == 64)
                queue_item(sha_pkg::OP_DIGEST, 8'h00);
        end

        // Random messages: mostly bytes, with digests, restarts and noise.
        n = 0;
        while (n < 36)
        begin
            r = $urandom_range(0, 99);
            if (r < 82)
                queue_item(sha_pkg::OP_ABSORB, 8'($urandom_range(0, 255)));
            else if (r < 93)
                queue_item(sha_pkg::OP_DIGEST, 8'($urandom_range(0, 255)));
            else if (r < 97)
                queue_item(sha_pkg::OP_RESTART, 8'($urandom_range(0, 255)));
            else
                queue_item(OP_UNUSED, 8'($urandom_range(0, 255)));
            n++;
        end
        queue_item(sha_pkg::OP_DIGEST, 8'h00);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d digest words from %0d digests over absorb, restart",
                 word_count, digest_count);
        $display("and ignored-op traffic, including padding across block edges.");
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

endmodule
